/* rtl/block_identity_classifier_defines.svh */
// Assertion macros shared by the block identity classifier RTL.
// Expects signals named clk and rst_n in the scope where the macros are used.
`ifndef BLOCK_IDENTITY_CLASSIFIER_DEFINES_SVH
`define BLOCK_IDENTITY_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define BIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define BIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bic_pkg.sv */
// Package for the block identity classifier: class codes, size limits and
// the byte-wide reflected CRC-32 step. No dependencies.
package bic_pkg;

  typedef enum logic [1:0] {
    KIND_ZERO      = 2'd0,
    KIND_ONES      = 2'd1,
    KIND_IDENTICAL = 2'd2,
    KIND_UNMATCHED = 2'd3
  } kind_t;

  localparam int unsigned SIZE_W          = 17;
  localparam int unsigned OFFSET_W        = 16;
  localparam int unsigned OUT_INDEX_W     = 40;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd4096;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd1;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
  localparam logic [7:0]  BYTE_ONES       = 8'hFF;

  // One byte of reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/block_identity_classifier.sv */
// Block identity classifier: takes one old/new image byte pair per word and
// gives one result word per block of block_size_bytes bytes.
// Input channel in_*: in_tdata holds old_byte and new_byte, in_tuser holds
// old_present and first_of_run. A word with first_of_run set drops any partial
// block and starts block 0. Result channel out_*: out_tdata holds the block
// index and the CRC-32 of the block (zero unless unmatched), out_tuser the
// class: all zero, all 0xFF, identical to the old block, or unmatched.
// Configuration port cfg_*: register 0 at byte address 0 is block_size_bytes;
// only bits 16:0 of a write are used; 0 reads back as 1, above 65536 as 65536.
// A word is held in the input register, and the result of the last word of a
// block is then written to the result register. Throughput is one word per
// cycle while the receiver does not stall, set by the combinational CRC byte
// step and flag update between the input and result registers.
// Reset (synchronous, rst_n low) empties both registers, sets the size to 4096
// and clears the block state. When the receiver stalls the result register
// holds its word; the input register still takes one more word, and in_tready
// falls only when both registers are full and out_tready is low.
`include "block_identity_classifier_defines.svh"

module block_identity_classifier
  import bic_pkg::*;
#(
  parameter int unsigned BLOCK_INDEX_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] old_byte, [15:8] new_byte
  input  logic [1:0]  in_tuser,   // [0] old_present, [1] first_of_run
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [39:0] block_index, [71:40] block_crc
  output logic [1:0]  out_tuser,  // [1:0] match_kind
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration register
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              cfg_wr;
  logic [SIZE_W-1:0] wr_val;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_old_r, s1_new_r;
  logic       s1_present_r, s1_first_r;

  // Block state
  logic [OFFSET_W-1:0]         off_r, off_nxt;
  logic [BLOCK_INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic                        az_r, az_nxt, ao_r, ao_nxt, eq_r, eq_nxt;
  logic [31:0]                 crc_r, crc_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_INDEX_W-1:0] out_index_r, out_index_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [31:0]            out_crc_r, out_crc_nxt;

  // Datapath
  logic                        out_free, proc;
  logic [OFFSET_W-1:0]         off_b;
  logic [BLOCK_INDEX_BITS-1:0] cnt_b;
  logic                        az_b, ao_b, eq_b, az_c, ao_c, eq_c;
  logic [31:0]                 crc_b, crc_c;
  logic [SIZE_W-1:0]           count;
  logic                        emit;
  kind_t                       kind_c;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-SIZE_W){1'b0}}, size_r};

  always_comb begin
    wr_val = cfg_pwdata[SIZE_W-1:0];
    if (wr_val == '0) begin
      wr_val = SIZE_MIN;
    end else if (wr_val > SIZE_MAX) begin
      wr_val = SIZE_MAX;
    end
    size_nxt = cfg_wr ? wr_val : size_r;
  end

  // The input register moves on whenever the result register can take a word.
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_comb begin
    // A restart mark discards the partial block before this byte is counted.
    off_b = s1_first_r ? '0 : off_r;
    cnt_b = s1_first_r ? '0 : cnt_r;
    az_b  = s1_first_r ? 1'b1 : az_r;
    ao_b  = s1_first_r ? 1'b1 : ao_r;
    eq_b  = s1_first_r ? 1'b1 : eq_r;
    crc_b = s1_first_r ? CRC_INIT : crc_r;

    az_c  = az_b && (s1_new_r == 8'd0);
    ao_c  = ao_b && (s1_new_r == BYTE_ONES);
    eq_c  = eq_b && s1_present_r && (s1_old_r == s1_new_r);
    crc_c = crc32_byte(crc_b, s1_new_r);

    count = {1'b0, off_b} + SIZE_W'(1);
    emit  = (count >= size_r);

    if (az_c) begin
      kind_c = KIND_ZERO;
    end else if (ao_c) begin
      kind_c = KIND_ONES;
    end else if (eq_c) begin
      kind_c = KIND_IDENTICAL;
    end else begin
      kind_c = KIND_UNMATCHED;
    end
  end

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    az_nxt        = az_r;
    ao_nxt        = ao_r;
    eq_nxt        = eq_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_index_nxt = out_index_r;
    out_kind_nxt  = out_kind_r;
    out_crc_nxt   = out_crc_r;
    if (proc) begin
      if (emit) begin
        off_nxt       = '0;
        cnt_nxt       = cnt_b + BLOCK_INDEX_BITS'(1);
        az_nxt        = 1'b1;
        ao_nxt        = 1'b1;
        eq_nxt        = 1'b1;
        crc_nxt       = CRC_INIT;
        out_valid_nxt = 1'b1;
        out_index_nxt = OUT_INDEX_W'(cnt_b);
        out_kind_nxt  = kind_c;
        out_crc_nxt   = (kind_c == KIND_UNMATCHED) ? ~crc_c : 32'd0;
      end else begin
        off_nxt = count[OFFSET_W-1:0];
        cnt_nxt = cnt_b;
        az_nxt  = az_c;
        ao_nxt  = ao_c;
        eq_nxt  = eq_c;
        crc_nxt = crc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      s1_valid_r  <= 1'b0;
      off_r       <= '0;
      cnt_r       <= '0;
      az_r        <= 1'b1;
      ao_r        <= 1'b1;
      eq_r        <= 1'b1;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      s1_valid_r  <= s1_valid_nxt;
      off_r       <= off_nxt;
      cnt_r       <= cnt_nxt;
      az_r        <= az_nxt;
      ao_r        <= ao_nxt;
      eq_r        <= eq_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_old_r     <= in_tdata[7:0];
      s1_new_r     <= in_tdata[15:8];
      s1_present_r <= in_tuser[0];
      s1_first_r   <= in_tuser[1];
    end
    out_index_r <= out_index_nxt;
    out_kind_r  <= out_kind_nxt;
    out_crc_r   <= out_crc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_crc_r, out_index_r};
  assign out_tuser  = out_kind_r;

  `BIC_ASSERT_IMP(a_crc_zero_unless_unmatched, out_valid_r && (out_kind_r != KIND_UNMATCHED), out_crc_r == 32'd0, "CRC field set on a matched block")
  `BIC_ASSERT_IMP(a_size_in_range, 1'b1, (size_r >= SIZE_MIN) && (size_r <= SIZE_MAX), "block size register out of range")
  `BIC_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), !out_valid_r && !s1_valid_r, "registers not empty after reset")
  `BIC_ASSERT_NXT(a_state_cleared_on_emit, proc && emit, (off_r == '0) && az_r && ao_r && eq_r && (crc_r == CRC_INIT) && out_valid_r, "block state not restarted after a result")

endmodule
